// ===== rtl/core/gps_trip_accumulator_assert.svh =====
// Assertion macros for the trip accumulator checker.
// No dependencies.
`ifndef GPS_TRIP_ACCUMULATOR_ASSERT_SVH
`define GPS_TRIP_ACCUMULATOR_ASSERT_SVH
// implication checked every clock outside reset
`define GTA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define GTA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/gta_pkg.sv =====
// Package for the trip accumulator: widths, CORDIC constants and angle table.
// No dependencies.
package gta_pkg;
  localparam int CordicIters = 30;
  localparam logic signed [33:0] GainInv = 34'sd652032874;
  localparam logic signed [33:0] Q30One = 34'sd1073741824;
  localparam logic [31:0] QuarterUnits = 32'd1800000000;
  localparam logic [32:0] HalfUnits = 33'd3600000000;
  localparam logic signed [30:0] LatLimit = 31'sd900000000;
  localparam logic [32:0] DistMult = 33'd4775785734;
  localparam logic [39:0] TotalMax = 40'hFF_FFFF_FFFF;
  localparam logic [23:0] Acc24Max = 24'hFF_FFFF;

  typedef logic signed [33:0] cval_t;

  function automatic logic [30:0] atan_lookup(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0: v = 31'd900000000;  5'd1: v = 31'd531301024;  5'd2: v = 31'd280724869;
      5'd3: v = 31'd142500327;  5'd4: v = 31'd71526687;   5'd5: v = 31'd35798212;
      5'd6: v = 31'd17903474;   5'd7: v = 31'd8952283;    5'd8: v = 31'd4476210;
      5'd9: v = 31'd2238114;    5'd10: v = 31'd1119058;   5'd11: v = 31'd559529;
      5'd12: v = 31'd279765;    5'd13: v = 31'd139882;    5'd14: v = 31'd69941;
      5'd15: v = 31'd34971;     5'd16: v = 31'd17485;     5'd17: v = 31'd8743;
      5'd18: v = 31'd4371;      5'd19: v = 31'd2186;      5'd20: v = 31'd1093;
      5'd21: v = 31'd546;       5'd22: v = 31'd273;       5'd23: v = 31'd137;
      5'd24: v = 31'd68;        5'd25: v = 31'd34;        5'd26: v = 31'd17;
      5'd27: v = 31'd9;         5'd28: v = 31'd4;         5'd29: v = 31'd2;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // command to the shared CORDIC unit
  typedef struct packed {
    logic        start;
    logic        vec_mode;
    cval_t       x0;
    cval_t       y0;
    logic signed [33:0] z0;
  } cordic_cmd_t;

  typedef struct packed {
    logic        done;
    cval_t       x;
    cval_t       y;
    logic signed [33:0] z;
  } cordic_rsp_t;

  typedef struct packed {
    logic        start;
    logic [61:0] radicand;
  } sqrt_cmd_t;

  typedef struct packed {
    logic        done;
    logic [30:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [23:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

// ===== rtl/core/gps_trip_accumulator.sv =====
// Trip accumulator: haversine segment length, speed and ride totals per fix.
// Handshake on in_/out_ valid and stall. Each accepted fix yields exactly one
// result transaction. An item is processed by a sequencer that drives one
// shared CORDIC unit (four rotations and one vectoring pass), a bit-serial
// square root (two passes), a 31-bit by 33-bit distance product built from
// four partial products, and a restoring divider for speed. The next fix is
// accepted once the result has been taken (in_stall is high from acceptance
// until then). The first fix after reset is its own predecessor: zero segment
// and speed. While out_stall is high the result holds on the out_ ports and
// no new fix is accepted. Synchronous active-low reset clears the stored fix
// and all totals and returns the sequencer to idle.
module gps_trip_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [17:0] in_altitude_dm,
  input  logic [23:0]        in_time_s,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_segment_cm,
  output logic [39:0]        out_total_cm,
  output logic [15:0]        out_speed_cm_per_s,
  output logic [23:0]        out_climb_dm,
  output logic [23:0]        out_descent_dm,
  output logic [23:0]        out_elapsed_s
);
  import gta_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ROT   = 14'b00000000000010,
    S_RWAIT = 14'b00000000000100,
    S_A1    = 14'b00000000001000,
    S_A2    = 14'b00000000010000,
    S_SQ    = 14'b00000000100000,
    S_SQW   = 14'b00000001000000,
    S_VEC   = 14'b00000010000000,
    S_VWAIT = 14'b00000100000000,
    S_MUL   = 14'b00001000000000,
    S_DIV   = 14'b00010000000000,
    S_DWAIT = 14'b00100000000000,
    S_UPD   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r;
  logic have_fix_r;
  logic signed [30:0] prev_lat_r, lat_r;
  logic signed [31:0] prev_lon_r, lon_r;
  logic signed [17:0] prev_alt_r, alt_r;
  logic [23:0] prev_time_r, tm_r;
  logic [39:0] total_r;
  logic [23:0] climb_r, descent_r;
  logic [1:0] k_r;
  logic signed [33:0] s1_r, s2_r, c1_r, c2_r;
  logic signed [33:0] prod_r, a_r, sy_r;
  logic sq_k_r;
  logic [1:0] m_r;
  logic [31:0] theta_r;
  logic [67:0] macc_r;
  logic [31:0] seg_r;

  cordic_cmd_t ccmd;
  cordic_rsp_t crsp;
  sqrt_cmd_t   scmd;
  sqrt_rsp_t   srsp;
  div_cmd_t    dcmd;
  div_rsp_t    drsp;

  gta_cordic u_cordic (.clk, .rst_n, .cmd(ccmd), .rsp(crsp));
  gta_sqrt   u_sqrt   (.clk, .rst_n, .cmd(scmd), .rsp(srsp));
  gta_div    u_div    (.clk, .rst_n, .cmd(dcmd), .rsp(drsp));

  // clamp latitude on entry
  logic signed [30:0] lat_in_c;
  always_comb begin
    if (in_latitude > LatLimit) lat_in_c = LatLimit;
    else if (in_latitude < -LatLimit) lat_in_c = -LatLimit;
    else lat_in_c = in_latitude;
  end

  // half-angle reduction into 0..90 degrees
  function automatic logic [31:0] reduce_half(input logic [32:0] d);
    logic [32:0] m;
    m = (d >= HalfUnits) ? d - HalfUnits : d;
    if (m >= HalfUnits) m = m - HalfUnits;
    if (m > {1'b0, QuarterUnits}) m = HalfUnits - m;
    return m[31:0];
  endfunction

  logic signed [32:0] dlat, dlon, alat0, alat1;
  logic [32:0] adlat, adlon;
  logic signed [33:0] rot_z;
  always_comb begin
    dlat = 33'(lat_r) - 33'(prev_lat_r);
    dlon = 33'(lon_r) - 33'(prev_lon_r);
    adlat = dlat[32] ? 33'(-dlat) : dlat;
    adlon = dlon[32] ? 33'(-dlon) : dlon;
    alat0 = prev_lat_r[30] ? -33'(prev_lat_r) : 33'(prev_lat_r);
    alat1 = lat_r[30] ? -33'(lat_r) : 33'(lat_r);
    case (k_r)
      2'd0: rot_z = 34'({1'b0, reduce_half(adlat)});
      2'd1: rot_z = 34'({1'b0, reduce_half(adlon)});
      2'd2: rot_z = {alat0, 1'b0};
      default: rot_z = {alat1, 1'b0};
    endcase
  end

  function automatic logic signed [33:0] clampq(input logic signed [33:0] v);
    if (v < 0) return '0;
    if (v > Q30One) return Q30One;
    return v;
  endfunction

  // Q30 product, one multiplier shared; operands are clamped to [0, 1.0]
  logic signed [33:0] mul_a, mul_b;
  logic [61:0] mul_p;
  always_comb begin
    mul_a = s1_r; mul_b = s1_r;
    unique case (state_r)
      S_A1: begin
        case (k_r)
          2'd0: begin mul_a = c1_r; mul_b = c2_r; end
          2'd1: begin mul_a = s2_r; mul_b = s2_r; end
          2'd2: begin mul_a = s1_r; mul_b = s1_r; end
          default: begin mul_a = prod_r; mul_b = c1_r; end
        endcase
      end
      default: ;
    endcase
    mul_p = mul_a[30:0] * mul_b[30:0];
  end

  // distance product: theta (31 bits) by DistMult (33 bits) in 17-bit halves
  logic [16:0] th_h, dm_h;
  logic [33:0] pp;
  always_comb begin
    th_h = m_r[1] ? {2'b0, theta_r[31:17]} : theta_r[16:0];
    dm_h = m_r[0] ? {1'b0, DistMult[32:17]} : DistMult[16:0];
    pp = th_h * dm_h;
  end
  logic [6:0] pp_sh;
  assign pp_sh = 7'(17 * (32'(m_r[1]) + 32'(m_r[0])));

  logic signed [18:0] dalt, ndalt;
  assign dalt = 19'(alt_r) - 19'(prev_alt_r);
  assign ndalt = -dalt;
  logic [40:0] tot_sum;
  logic [24:0] cl_sum, de_sum;
  logic [31:0] seg_use;
  logic same_pos;
  assign same_pos = (lat_r == prev_lat_r && lon_r == prev_lon_r);
  assign seg_use = same_pos ? 32'd0 : seg_r;
  assign tot_sum = {1'b0, total_r} + 41'(seg_use);
  assign cl_sum = {1'b0, climb_r} + 25'(dalt[17:0]);
  assign de_sum = {1'b0, descent_r} + 25'(ndalt[17:0]);

  always_comb begin
    ccmd = '0;
    scmd = '0;
    dcmd = '0;
    ccmd.start = (state_r == S_ROT) || (state_r == S_VEC);
    ccmd.vec_mode = (state_r == S_VEC);
    ccmd.x0 = (state_r == S_VEC) ? prod_r : GainInv;
    ccmd.y0 = (state_r == S_VEC) ? sy_r : '0;
    ccmd.z0 = (state_r == S_VEC) ? '0 : rot_z;
    scmd.start = (state_r == S_SQ);
    scmd.radicand = sq_k_r ? {32'(Q30One - a_r), 30'd0} : {32'(a_r), 30'd0};
    dcmd.start = (state_r == S_DIV);
    // the product is complete here, ahead of seg_r
    dcmd.dividend = same_pos ? 32'd0 : macc_r[63:32];
    dcmd.divisor = tm_r - prev_time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      have_fix_r <= 1'b0;
      prev_lat_r <= '0; prev_lon_r <= '0; prev_alt_r <= '0; prev_time_r <= '0;
      total_r <= '0; climb_r <= '0; descent_r <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          lat_r <= lat_in_c; lon_r <= in_longitude;
          alt_r <= in_altitude_dm; tm_r <= in_time_s;
          if (!have_fix_r) begin
            prev_lat_r <= lat_in_c; prev_lon_r <= in_longitude;
            prev_alt_r <= in_altitude_dm; prev_time_r <= in_time_s;
            have_fix_r <= 1'b1;
          end
          k_r <= 2'd0;
          state_r <= S_ROT;
        end
        S_ROT: state_r <= S_RWAIT;
        S_RWAIT: if (crsp.done) begin
          case (k_r)
            2'd0: s1_r <= clampq(crsp.y);
            2'd1: s2_r <= clampq(crsp.y);
            2'd2: c1_r <= clampq(crsp.x);
            default: c2_r <= clampq(crsp.x);
          endcase
          k_r <= k_r + 2'd1;
          state_r <= (k_r == 2'd3) ? S_A1 : S_ROT;
        end
        // k: 0 cc=c1*c2, 1 s2^2, 2 s1^2, 3 t=cc*s2^2
        S_A1: begin
          case (k_r)
            2'd0: prod_r <= 34'(mul_p >> 30);
            2'd1: c1_r <= 34'(mul_p >> 30);
            2'd2: s1_r <= 34'(mul_p >> 30);
            default: a_r <= 34'(mul_p >> 30);
          endcase
          if (k_r == 2'd1) begin
            k_r <= 2'd2;
          end else if (k_r == 2'd0) begin
            k_r <= 2'd1;
          end else if (k_r == 2'd2) begin
            k_r <= 2'd3;
          end else state_r <= S_A2;
        end
        S_A2: begin
          a_r <= clampq(s1_r + a_r);
          sq_k_r <= 1'b0;
          state_r <= S_SQ;
        end
        S_SQ: state_r <= S_SQW;
        S_SQW: if (srsp.done) begin
          if (!sq_k_r) begin
            sy_r <= 34'(srsp.root);
            sq_k_r <= 1'b1;
            state_r <= S_SQ;
          end else begin
            prod_r <= 34'(srsp.root);
            state_r <= S_VEC;
          end
        end
        S_VEC: state_r <= S_VWAIT;
        S_VWAIT: if (crsp.done) begin
          if (crsp.z < 0) theta_r <= '0;
          else if (crsp.z > 34'(QuarterUnits)) theta_r <= QuarterUnits;
          else theta_r <= crsp.z[31:0];
          m_r <= 2'd0;
          macc_r <= 68'd2147483648;
          state_r <= S_MUL;
        end
        S_MUL: begin
          macc_r <= macc_r + (68'(pp) << pp_sh);
          m_r <= m_r + 2'd1;
          if (m_r == 2'd3) state_r <= S_DIV;
        end
        S_DIV: begin
          seg_r <= macc_r[63:32];
          state_r <= S_DWAIT;
        end
        S_DWAIT: if (drsp.done) state_r <= S_UPD;
        S_UPD: begin
          out_segment_cm <= seg_use;
          total_r <= tot_sum[40] ? TotalMax : tot_sum[39:0];
          out_total_cm <= tot_sum[40] ? TotalMax : tot_sum[39:0];
          if (tm_r > prev_time_r)
            out_speed_cm_per_s <= (drsp.quotient > 32'd65535) ? 16'hFFFF
                                  : drsp.quotient[15:0];
          else out_speed_cm_per_s <= '0;
          if (dalt > 0) begin
            climb_r <= cl_sum[24] ? Acc24Max : cl_sum[23:0];
            out_climb_dm <= cl_sum[24] ? Acc24Max : cl_sum[23:0];
            out_descent_dm <= descent_r;
          end else begin
            descent_r <= de_sum[24] ? Acc24Max : de_sum[23:0];
            out_descent_dm <= de_sum[24] ? Acc24Max : de_sum[23:0];
            out_climb_dm <= climb_r;
          end
          out_elapsed_s <= tm_r;
          prev_lat_r <= lat_r; prev_lon_r <= lon_r;
          prev_alt_r <= alt_r; prev_time_r <= tm_r;
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
endmodule

// ===== rtl/core/gta_cordic.sv =====
// Shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring.
// Depends on gta_pkg.
module gta_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gta_pkg::cordic_cmd_t cmd,
  output gta_pkg::cordic_rsp_t rsp
);
  import gta_pkg::*;

  cval_t x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [33:0] z_r, z_nxt, at;
  logic [4:0] i_r;
  logic busy_r, mode_r, dir, done_r;

  always_comb begin
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = 34'(signed'({1'b0, atan_lookup(i_r)}));
    dir = mode_r ? (y_r > 0) : ~z_r[33];
    if (mode_r) begin
      x_nxt = dir ? x_r + dx : x_r - dx;
      y_nxt = dir ? y_r - dy : y_r + dy;
      z_nxt = dir ? z_r + at : z_r - at;
    end else begin
      x_nxt = dir ? x_r - dx : x_r + dx;
      y_nxt = dir ? y_r + dy : y_r - dy;
      z_nxt = dir ? z_r - at : z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        i_r <= '0;
        mode_r <= cmd.vec_mode;
        x_r <= cmd.x0; y_r <= cmd.y0; z_r <= cmd.z0;
      end else if (busy_r) begin
        x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
        i_r <= i_r + 5'd1;
        if (i_r == 5'(CordicIters - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.x = x_r;
  assign rsp.y = y_r;
  assign rsp.z = z_r;
endmodule

// ===== rtl/core/gta_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on gta_pkg.
module gta_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  gta_pkg::sqrt_cmd_t cmd,
  output gta_pkg::sqrt_rsp_t rsp
);
  import gta_pkg::*;

  logic [61:0] rem_r;
  logic [30:0] root_r;
  logic [4:0] n_r;
  logic busy_r, done_r;
  logic [32:0] trial;

  always_comb begin
    trial = {root_r, 2'b01};
  end

  // remainder kept as a separate partial value
  logic [32:0] part_r;
  logic [32:0] part_sh;
  always_comb part_sh = {part_r[30:0], rem_r[61:60]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        rem_r <= cmd.radicand;
        root_r <= '0;
        part_r <= '0;
        n_r <= '0;
      end else if (busy_r) begin
        rem_r <= {rem_r[59:0], 2'b00};
        if (part_sh >= trial) begin
          part_r <= part_sh - trial;
          root_r <= {root_r[29:0], 1'b1};
        end else begin
          part_r <= part_sh;
          root_r <= {root_r[29:0], 1'b0};
        end
        n_r <= n_r + 5'd1;
        if (n_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;
endmodule

// ===== rtl/core/gta_div.sv =====
// Restoring divider for the speed quotient, one quotient bit per cycle.
// Depends on gta_pkg.
module gta_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gta_pkg::div_cmd_t cmd,
  output gta_pkg::div_rsp_t rsp
);
  import gta_pkg::*;

  logic [31:0] q_r;
  logic [24:0] rem_r;
  logic [23:0] d_r;
  logic [4:0] n_r;
  logic busy_r, done_r;
  logic [24:0] sh;

  assign sh = {rem_r[23:0], q_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        q_r <= cmd.dividend;
        d_r <= cmd.divisor;
        rem_r <= '0;
        n_r <= '0;
      end else if (busy_r) begin
        if (sh >= {1'b0, d_r}) begin
          rem_r <= sh - {1'b0, d_r};
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r <= {q_r[30:0], 1'b0};
        end
        n_r <= n_r + 5'd1;
        if (n_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = q_r;
endmodule

// ===== rtl/core/gta_checker.sv =====
// Port-level checker for the trip accumulator, bound to the top level.
// Depends on gps_trip_accumulator_assert.svh.
`include "gps_trip_accumulator_assert.svh"
module gta_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_elapsed_s,
  input logic [39:0] out_total_cm
);
  `GTA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `GTA_ASSERT_IMP(a_no_accept_with_result, out_valid, in_stall)
  `GTA_ASSERT_NXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(out_total_cm))
  `GTA_ASSERT_NXT(a_elapsed_held, out_valid && out_stall, $stable(out_elapsed_s))
  `GTA_ASSERT_NXT(a_no_result_after_accept, in_valid && !in_stall,
    !out_valid)
endmodule

bind gps_trip_accumulator gta_checker u_gta_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_elapsed_s, .out_total_cm
);
